[rtl/efb_pkg.sv]
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types, constants and the byte-wide CRC-32 step for the Ethernet II
// frame builder.
// ----------------------------------------------------------------------------
package efb_pkg;

    localparam int unsigned MAC_W   = 48;
    localparam int unsigned TYPE_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned HDR_W   = 2 * MAC_W + TYPE_W;
    localparam int unsigned PHASE_W = 5;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [CRC_W-1:0]   crc_t;

    localparam crc_t CRC_POLY   = 32'hEDB8_8320;
    localparam crc_t CRC_PRESET = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic REG_SOURCE_MAC   = 1'b0;
    localparam logic REG_TABLES_READY = 1'b1;

    // Byte sequence of one item: header bytes, payload byte, FCS bytes
    localparam phase_t PHASE_HDR_FIRST = 5'd0;
    localparam phase_t PHASE_HDR_LAST  = 5'd13;
    localparam phase_t PHASE_DATA      = 5'd14;
    localparam phase_t PHASE_FCS_FIRST = 5'd15;
    localparam phase_t PHASE_FCS_LAST  = 5'd18;

    function automatic crc_t crc32_byte(input crc_t crc_in, input logic [BYTE_W-1:0] data);
        crc_t c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

endpackage

[rtl/ethernet_frame_builder_fcs_unit.sv]
// ----------------------------------------------------------------------------
// ethernet_frame_builder_fcs_unit
// Ethernet II transmit framer: header insertion, payload pass-through and
// CRC-32 frame check sequence append, one byte per beat.
// ----------------------------------------------------------------------------
// Items pass through the item register, bytes through the output register.
// Throughput: one output byte per cycle while out_stall is low; an item holds
// the item register until all its bytes (1 to 19) are out, so payload items
// flow at one per cycle unstalled. Items with no bytes are taken and dropped.
// Reset: asynchronous, active low; clears config, frame and output state and
// presets the CRC to all ones.
module ethernet_frame_builder_fcs_unit
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [efb_pkg::MAC_W-1:0]         cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [efb_pkg::BYTE_W-1:0]        payload_byte,
    input  logic                              payload_present,
    input  logic [efb_pkg::MAC_W-1:0]         dest_mac,
    input  logic [efb_pkg::TYPE_W-1:0]        frame_type,
    input  logic                              last_byte,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [efb_pkg::BYTE_W-1:0]        out_byte,
    output logic                              out_last
);

    logic [efb_pkg::MAC_W-1:0]  source_mac_reg;
    logic                       tables_ready_reg;
    logic                       frame_open_reg;
    logic                       frame_open_next;
    efb_pkg::crc_t              crc_reg;
    efb_pkg::crc_t              crc_next;

    logic                       item_valid_reg;
    logic                       item_valid_next;
    efb_pkg::phase_t            phase_reg;
    efb_pkg::phase_t            phase_next;
    efb_pkg::phase_t            start_phase;
    efb_pkg::phase_t            follow_phase;
    logic                       item_end;

    logic [efb_pkg::BYTE_W-1:0] pay_reg;
    logic                       present_reg;
    logic                       last_reg;
    logic [efb_pkg::MAC_W-1:0]  dest_reg;
    logic [efb_pkg::TYPE_W-1:0] type_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [efb_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       out_last_reg;

    logic                       in_take;
    logic                       item_load;
    logic                       emit;
    logic [efb_pkg::HDR_W-1:0]  hdr_shift;
    logic [efb_pkg::BYTE_W-1:0] emit_byte;
    logic                       emit_last;
    efb_pkg::crc_t              fcs;
    logic [1:0]                 fcs_sel;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mac_reg   <= '0;
            tables_ready_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                efb_pkg::REG_SOURCE_MAC:   source_mac_reg   <= cfg_data;
                efb_pkg::REG_TABLES_READY: tables_ready_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Sequencing
    assign emit     = item_valid_reg && (!out_valid_reg || !out_stall);
    assign item_end = emit && (follow_phase == efb_pkg::PHASE_HDR_FIRST);
    assign in_stall = item_valid_reg && !item_end;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (!frame_open_reg)
        begin
            start_phase = efb_pkg::PHASE_HDR_FIRST;
        end
        else if (payload_present)
        begin
            start_phase = efb_pkg::PHASE_DATA;
        end
        else
        begin
            start_phase = efb_pkg::PHASE_FCS_FIRST;
        end
    end

    assign item_load = in_take && tables_ready_reg
                       && (!frame_open_reg || payload_present || last_byte);

    // PHASE_HDR_FIRST doubles as "no further byte" since a header never follows
    always_comb
    begin
        follow_phase = efb_pkg::PHASE_HDR_FIRST;
        if (phase_reg < efb_pkg::PHASE_HDR_LAST)
        begin
            follow_phase = phase_reg + efb_pkg::phase_t'(1);
        end
        else if (phase_reg == efb_pkg::PHASE_HDR_LAST)
        begin
            if (present_reg)
            begin
                follow_phase = efb_pkg::PHASE_DATA;
            end
            else if (last_reg)
            begin
                follow_phase = efb_pkg::PHASE_FCS_FIRST;
            end
        end
        else if (phase_reg == efb_pkg::PHASE_DATA)
        begin
            if (last_reg)
            begin
                follow_phase = efb_pkg::PHASE_FCS_FIRST;
            end
        end
        else if (phase_reg < efb_pkg::PHASE_FCS_LAST)
        begin
            follow_phase = phase_reg + efb_pkg::phase_t'(1);
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        phase_next      = phase_reg;
        frame_open_next = frame_open_reg;
        if (emit)
        begin
            phase_next = follow_phase;
            if (item_end)
            begin
                item_valid_next = 1'b0;
            end
        end
        if (in_take && tables_ready_reg)
        begin
            frame_open_next = !last_byte;
        end
        if (item_load)
        begin
            item_valid_next = 1'b1;
            phase_next      = start_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= efb_pkg::PHASE_HDR_FIRST;
            frame_open_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            frame_open_reg <= frame_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            pay_reg     <= payload_byte;
            present_reg <= payload_present;
            last_reg    <= last_byte;
            dest_reg    <= dest_mac;
            type_reg    <= frame_type;
        end
    end

    // Byte selection and CRC
    assign hdr_shift = {dest_reg, source_mac_reg, type_reg}
                       << {phase_reg, 3'b000};
    assign fcs       = ~crc_reg;
    assign fcs_sel   = 2'(phase_reg - efb_pkg::PHASE_FCS_FIRST);

    always_comb
    begin
        emit_last = 1'b0;
        if (phase_reg <= efb_pkg::PHASE_HDR_LAST)
        begin
            emit_byte = hdr_shift[efb_pkg::HDR_W-1 -: efb_pkg::BYTE_W];
        end
        else if (phase_reg == efb_pkg::PHASE_DATA)
        begin
            emit_byte = pay_reg;
        end
        else
        begin
            emit_byte = fcs[{fcs_sel, 3'b000} +: efb_pkg::BYTE_W];
            emit_last = (phase_reg == efb_pkg::PHASE_FCS_LAST);
        end
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (emit)
        begin
            if (phase_reg == efb_pkg::PHASE_HDR_FIRST)
            begin
                crc_next = efb_pkg::crc32_byte(efb_pkg::CRC_PRESET, emit_byte);
            end
            else if (phase_reg <= efb_pkg::PHASE_DATA)
            begin
                crc_next = efb_pkg::crc32_byte(crc_reg, emit_byte);
            end
            else if (phase_reg == efb_pkg::PHASE_FCS_LAST)
            begin
                crc_next = efb_pkg::CRC_PRESET;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= efb_pkg::CRC_PRESET;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    // Output register
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> phase_reg <= efb_pkg::PHASE_FCS_LAST)
        else $error("phase beyond last FCS byte");

    a_crc_preset_after_fcs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> crc_reg == efb_pkg::CRC_PRESET)
        else $error("CRC not preset after final FCS byte");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg)
        else $error("input stalled with no item held");

    a_no_emit_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_byte_reg))
        else $error("output beat changed while stalled");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Ethernet II frame builder. A queue-fed driver
// sends payload beats and a monitor predicts the header, payload and FCS bytes
// of each accepted beat. The monitor checks every output byte in order. Phases
// change the station address and the tables-ready flag, and vary sender gaps
// and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] FCS_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] FCS_PRESET = 32'hFFFF_FFFF;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct {
        logic [efb_pkg::BYTE_W-1:0] pbyte;
        logic                       present;
        logic [efb_pkg::MAC_W-1:0]  dest;
        logic [efb_pkg::TYPE_W-1:0] ftype;
        logic                       last;
    } tx_item_t;

    typedef struct {
        logic [efb_pkg::BYTE_W-1:0] data;
        logic                       last;
    } wire_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic                       cfg_index = 1'b0;
    logic [efb_pkg::MAC_W-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [efb_pkg::BYTE_W-1:0] payload_byte = '0;
    logic                       payload_present = 1'b0;
    logic [efb_pkg::MAC_W-1:0]  dest_mac = '0;
    logic [efb_pkg::TYPE_W-1:0] frame_type = '0;
    logic                       last_byte = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [efb_pkg::BYTE_W-1:0] out_byte;
    logic                       out_last;

    tx_item_t   tx_items_pending[$];
    wire_beat_t wire_bytes_due[$];

    logic [efb_pkg::MAC_W-1:0] source_mac_q = '0;
    logic                      tables_ready_q = 1'b0;
    logic                      frame_open_q = 1'b0;
    logic [31:0]               fcs_acc = FCS_PRESET;

    logic       in_taken = 1'b0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         mismatches = 0;
    int         items_taken = 0;
    int         frames_closed = 0;
    int         bytes_checked = 0;
    int         reg_writes = 0;
    wire_beat_t seen_want;
    tx_item_t   next_item;
    tx_item_t   taken_item;

    ethernet_frame_builder_fcs_unit uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .payload_byte    (payload_byte),
        .payload_present (payload_present),
        .dest_mac        (dest_mac),
        .frame_type      (frame_type),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .out_last        (out_last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] fcs_fold(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c = c >> 1;
            if (fb)
                c = c ^ FCS_POLY;
        end
        return c;
    endfunction

    task automatic emit_frame_byte(input logic [efb_pkg::BYTE_W-1:0] d);
        wire_beat_t b;
        b.data = d;
        b.last = 1'b0;
        wire_bytes_due.push_back(b);
        fcs_acc = fcs_fold(fcs_acc, d);
    endtask

    task automatic predict_wire_bytes(input tx_item_t it);
        logic [31:0] fcs;
        wire_beat_t  b;
        if (!tables_ready_q)
            return;
        if (!frame_open_q)
        begin
            fcs_acc = FCS_PRESET;
            for (int i = 5; i >= 0; i--)
                emit_frame_byte(it.dest[8*i +: 8]);
            for (int i = 5; i >= 0; i--)
                emit_frame_byte(source_mac_q[8*i +: 8]);
            emit_frame_byte(it.ftype[15:8]);
            emit_frame_byte(it.ftype[7:0]);
            frame_open_q = 1'b1;
        end
        if (it.present)
            emit_frame_byte(it.pbyte);
        if (it.last)
        begin
            fcs = ~fcs_acc;
            for (int i = 0; i < 4; i++)
            begin
                b.data = fcs[8*i +: 8];
                b.last = (i == 3);
                wire_bytes_due.push_back(b);
            end
            frame_open_q = 1'b0;
            fcs_acc = FCS_PRESET;
            frames_closed++;
        end
    endtask

    // drive beats and receiver stalls on the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        if (!in_valid || in_taken)
        begin
            if (tx_items_pending.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                next_item = tx_items_pending.pop_front();
                payload_byte    <= next_item.pbyte;
                payload_present <= next_item.present;
                dest_mac        <= next_item.dest;
                frame_type      <= next_item.ftype;
                last_byte       <= next_item.last;
                in_valid        <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (out_valid && !out_stall)
        begin
            if (wire_bytes_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                         $time, out_byte, out_last);
            end
            else
            begin
                seen_want = wire_bytes_due.pop_front();
                bytes_checked++;
                if (out_byte !== seen_want.data)
                begin
                    mismatches++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, seen_want.data, out_byte);
                end
                if (out_last !== seen_want.last)
                begin
                    mismatches++;
                    $display("%0t: out_last mismatch: expected %0b, actual %0b",
                             $time, seen_want.last, out_last);
                end
            end
        end
        if (in_valid && !in_stall)
        begin
            taken_item.pbyte   = payload_byte;
            taken_item.present = payload_present;
            taken_item.dest    = dest_mac;
            taken_item.ftype   = frame_type;
            taken_item.last    = last_byte;
            items_taken++;
            predict_wire_bytes(taken_item);
        end
        if (cfg_we)
        begin
            if (cfg_index == efb_pkg::REG_SOURCE_MAC)
                source_mac_q = cfg_data;
            else if (cfg_index == efb_pkg::REG_TABLES_READY)
                tables_ready_q = cfg_data[0];
        end
    end

    task automatic write_reg(input logic idx, input logic [efb_pkg::MAC_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    task automatic add_item(input logic [efb_pkg::BYTE_W-1:0] pbyte, input logic present,
                            input logic [efb_pkg::MAC_W-1:0] dest,
                            input logic [efb_pkg::TYPE_W-1:0] ftype,
                            input logic last);
        tx_item_t it;
        it.pbyte   = pbyte;
        it.present = present;
        it.dest    = dest;
        it.ftype   = ftype;
        it.last    = last;
        tx_items_pending.push_back(it);
    endtask

    function automatic logic [efb_pkg::MAC_W-1:0] random_mac();
        logic [efb_pkg::MAC_W-1:0] m;
        m[47:32] = 16'($urandom);
        m[31:0]  = $urandom;
        return m;
    endfunction

    task automatic queue_random_beats(input int target);
        int count;
        int len;
        count = 0;
        while (count < target)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    add_item(8'($urandom), $urandom_range(99) >= 15, random_mac(),
                             16'($urandom), k == len - 1);
                count += len;
            end
            else
            begin
                add_item(8'($urandom), 1'($urandom_range(1)), random_mac(), 16'($urandom),
                         1'($urandom_range(1)));
                count++;
            end
        end
    endtask

    task automatic settle();
        while (tx_items_pending.size() != 0 || in_valid)
            @(posedge clk);
        while (wire_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(efb_pkg::REG_SOURCE_MAC, {efb_pkg::MAC_W{1'b1}});
        write_reg(efb_pkg::REG_TABLES_READY, 48'd1);
        add_item(8'hFF, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        add_item(8'h00, 1'b1, 48'h0000_0000_0000, 16'h0000, 1'b1);
        add_item(8'h00, 1'b0, 48'hAAAA_AAAA_AAAA, 16'h5555, 1'b1);
        add_item(8'h5A, 1'b1, 48'h5555_5555_5555, 16'hAAAA, 1'b0);
        add_item(8'h00, 1'b0, 48'h0000_0000_0000, 16'h0000, 1'b0);
        add_item(8'hC3, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
        add_item(8'h00, 1'b0, 48'h0000_0000_0001, 16'h0001, 1'b1);
        add_item(8'h81, 1'b0, 48'h1234_5678_9ABC, 16'h0800, 1'b0);
        add_item(8'h7E, 1'b1, 48'h0000_0000_0000, 16'h0000, 1'b1);
        add_item(8'hAA, 1'b1, 48'h0180_C200_0000, 16'h86DD, 1'b1);
        add_item(8'h55, 1'b1, 48'h8000_0000_0000, 16'h8000, 1'b1);
        add_item(8'h11, 1'b1, 48'h0180_C200_0000, 16'h86DD, 1'b0);
        add_item(8'h22, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
        settle();

        // hold the open frame while the tables are not ready
        write_reg(efb_pkg::REG_TABLES_READY, 48'd0);
        add_item(8'h33, 1'b1, 48'h0000_0000_0000, 16'h0000, 1'b0);
        add_item(8'h44, 1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        add_item(8'h55, 1'b1, 48'h0102_0304_0506, 16'h0806, 1'b1);
        settle();

        gap_pct = 61;
        write_reg(efb_pkg::REG_SOURCE_MAC, 48'd0);
        write_reg(efb_pkg::REG_TABLES_READY, 48'd1);
        queue_random_beats(100);
        settle();

        gap_pct = 0;
        stall_pct = 61;
        write_reg(efb_pkg::REG_SOURCE_MAC, random_mac());
        queue_random_beats(100);
        settle();

        gap_pct = 33;
        stall_pct = 33;
        write_reg(efb_pkg::REG_SOURCE_MAC, random_mac());
        queue_random_beats(100);
        settle();

        gap_pct = 0;
        stall_pct = 0;
        write_reg(efb_pkg::REG_SOURCE_MAC, 48'h5555_5555_5555);
        write_reg(efb_pkg::REG_TABLES_READY, 48'd1);
        queue_random_beats(100);
        settle();

        $display("Run took %0d beats and closed %0d frames; %0d frame bytes were checked.",
                 items_taken, frames_closed, bytes_checked);
        $display("%0d register writes covered address extremes, dropped beats and idle mixes.",
                 reg_writes);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d frame bytes outstanding", wire_bytes_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
